// File: design/rsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared widths, operation codes, cell commands and divider request and reply types for the stack calculator.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int DATA_W      = 32;
  localparam int OP_W        = 4;
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int STEP_W      = $clog2(DATA_W);

  // Token operation codes
  localparam logic [OP_W-1:0] OP_PUSH  = 4'd0;
  localparam logic [OP_W-1:0] OP_PRINT = 4'd1;
  localparam logic [OP_W-1:0] OP_SWAP  = 4'd2;
  localparam logic [OP_W-1:0] OP_DUP   = 4'd3;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd4;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd6;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd7;

  // What a stack cell loads on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_UP,
    CELL_FROM_DOWN
  } cell_cmd_t;

  // Divider request and reply
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: design/rsa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_cell
// One stack entry: holds its word or takes it from the neighbor above
// (toward the top) or below (toward the bottom).
// ----------------------------------------------------------------------------
module rsa_cell (
  input  logic                      clk,
  input  rsa_pkg::cell_cmd_t        cmd,
  input  logic [rsa_pkg::DATA_W-1:0] up_data,
  input  logic [rsa_pkg::DATA_W-1:0] down_data,
  output logic [rsa_pkg::DATA_W-1:0] data
);
  import rsa_pkg::*;

  // Hold or shift one place
  always_ff @(posedge clk) begin
    case (cmd)
      CELL_FROM_UP:   data <= up_data;
      CELL_FROM_DOWN: data <= down_data;
      default:        data <= data;
    endcase
  end

endmodule

// File: design/rsa_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_divider
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle
// (restoring). A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module rsa_divider (
  input  logic              clk,
  input  logic              rst,
  input  rsa_pkg::div_req_t req,
  output rsa_pkg::div_rsp_t rsp
);
  import rsa_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step_cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] mag_b;
  logic              neg_q;
  logic              zero_b;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] mag_a_in;
  logic [DATA_W-1:0] mag_b_in;

  // Magnitudes of the incoming operands
  assign mag_a_in = req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
  assign mag_b_in = req.divisor[DATA_W-1]  ? (~req.divisor + 1'b1)  : req.divisor;

  // Trial subtract of the shifted partial remainder
  assign trial = {rem, quo[DATA_W-1]} - {1'b0, mag_b};

  // Control: run DATA_W steps after a start, then flag done for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        step_cnt <= STEP_W'(DATA_W - 1);
      end else if (busy) begin
        if (step_cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step_cnt <= step_cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: load magnitudes, then shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem    <= '0;
      quo    <= mag_a_in;
      mag_b  <= mag_b_in;
      neg_q  <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
      zero_b <= (req.divisor == '0);
    end else if (busy) begin
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DATA_W-2:0], quo[DATA_W-1]};
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Apply the sign, force zero on a zero divisor
  assign rsp.done     = done;
  assign rsp.quotient = zero_b ? '0 : (neg_q ? (~quo + 1'b1) : quo);

endmodule

// File: design/rpn_stack_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_alu
// Reverse Polish stack calculator on decoded tokens.
// ----------------------------------------------------------------------------
// The stack is a row of STACK_DEPTH cells with the top in cell 0; push and
// dup shift the row down, arithmetic shifts it up, swap exchanges the first
// two cells. Push, print, swap, dup, add, sub, mul and ignore tokens leave
// the sequencer idle. A div token with two or more entries holds off all
// input until the bit-serial divider, at one quotient bit per cycle, is
// done and the quotient is written back to the top cell. A print result sits
// in an output register; further non-print tokens are still taken while it
// waits, and a second print waits until the first result is transferred.
// ----------------------------------------------------------------------------
module rpn_stack_alu (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rsa_pkg::OP_W-1:0]          operation,
  input  logic signed [rsa_pkg::DATA_W-1:0] operand_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rsa_pkg::DATA_W-1:0] printed_value
);
  import rsa_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic              state;
  logic [CNT_W-1:0]  count;
  logic              accept;
  logic              has1;
  logic              has2;
  logic              full;
  logic              do_push;
  logic              do_dup;
  logic              do_swap;
  logic              do_alu;
  logic              do_div;
  logic              do_print;
  logic              div_wb;
  logic              grow;
  logic              shrink;
  logic [DATA_W-1:0] alu_result;
  logic [DATA_W-1:0] head;
  logic [DATA_W-1:0] cell_data [STACK_DEPTH];
  cell_cmd_t         cell_cmd  [STACK_DEPTH];
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Input handshake: ready only in idle; a print also waits on a full output
  assign in_ready = (state == ST_IDLE)
                    && (!out_valid || out_ready || (operation != OP_PRINT));
  assign accept   = in_valid && in_ready;

  // Stack occupancy
  assign has1 = (count != '0);
  assign has2 = (count > CNT_W'(1));
  assign full = (count == CNT_W'(STACK_DEPTH));

  // Decode the transferred token
  assign do_push  = accept && (operation == OP_PUSH) && !full;
  assign do_dup   = accept && (operation == OP_DUP) && has1 && !full;
  assign do_swap  = accept && (operation == OP_SWAP) && has2;
  assign do_print = accept && (operation == OP_PRINT) && has1;
  assign do_alu   = accept && has2
                    && ((operation == OP_ADD) || (operation == OP_SUB)
                        || (operation == OP_MUL));
  assign do_div   = accept && (operation == OP_DIV) && has2;
  assign div_wb   = (state == ST_DIV) && div_rsp.done;
  assign grow     = do_push || do_dup;
  assign shrink   = do_alu || div_wb;

  // Combinational arithmetic on the top two cells
  always_comb begin
    case (operation)
      OP_ADD:  alu_result = cell_data[1] + cell_data[0];
      OP_SUB:  alu_result = cell_data[1] - cell_data[0];
      default: alu_result = DATA_W'(cell_data[1] * cell_data[0]);
    endcase
  end

  // Word entering the top cell
  always_comb begin
    if (do_push)      head = operand_value;
    else if (do_dup)  head = cell_data[0];
    else if (div_wb)  head = div_rsp.quotient;
    else              head = alu_result;
  end

  // Row of stack cells
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_data;
    logic [DATA_W-1:0] down_data;

    if (i == 0) begin : g_top
      assign up_data = head;
    end else begin : g_mid
      assign up_data = cell_data[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_data = cell_data[i];
    end else begin : g_inner
      assign down_data = cell_data[i+1];
    end

    // Per-cell command
    always_comb begin
      cell_cmd[i] = CELL_HOLD;
      if (i == 0) begin
        if (grow || shrink) cell_cmd[i] = CELL_FROM_UP;
        else if (do_swap)   cell_cmd[i] = CELL_FROM_DOWN;
      end else begin
        if (grow || (do_swap && (i == 1))) cell_cmd[i] = CELL_FROM_UP;
        else if (shrink)                   cell_cmd[i] = CELL_FROM_DOWN;
      end
    end

    rsa_cell u_cell (
      .clk       (clk),
      .cmd       (cell_cmd[i]),
      .up_data   (up_data),
      .down_data (down_data),
      .data      (cell_data[i])
    );
  end

  // Divider: second over top
  assign div_req.start    = do_div;
  assign div_req.dividend = cell_data[1];
  assign div_req.divisor  = cell_data[0];

  rsa_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (do_div) state <= ST_DIV;
        ST_DIV:  if (div_rsp.done) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      if (grow)        count <= count + 1'b1;
      else if (shrink) count <= count - 1'b1;
    end
  end

  // Output register: load on print, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_print) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_print) printed_value <= cell_data[0];
  end

`ifndef NO_ASSERTIONS
  // Count never exceeds the stack depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  // Count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count)) || (count == $past(count) + 1'b1)
                    || (count == $past(count) - 1'b1))
    else $error("stack count jumped");

  // Divider only finishes while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider done outside divide state");

  // A print presents the top cell on the next cycle
  a_print: assert property (@(posedge clk) disable iff (rst)
    do_print |=> out_valid && (printed_value == $past(cell_data[0])))
    else $error("print result not presented");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the RPN stack calculator.
// ----------------------------------------------------------------------------
// A shadow stack follows every token that the block takes and queues the value
// that each print should produce. The testbench checks every printed result in
// order against that queue. A short directed run covers the empty and
// single-entry cases, wrapping arithmetic and the division corner cases.
// Random bursts follow. Some bursts fill the stack, some drain it and some mix
// tokens. This is done under three idle patterns: the sender mostly busy, the
// receiver mostly busy, and neither idling.
// ----------------------------------------------------------------------------

class calc_scoreboard;
  logic [31:0] slots [rsa_pkg::STACK_DEPTH];
  int unsigned depth;
  logic [31:0] expected_prints [$];
  int errors;

  function new();
    depth  = 0;
    errors = 0;
  endfunction

  // Signed division truncating toward zero; a zero divisor gives zero
  static function logic [31:0] quotient_trunc(logic [31:0] num, logic [31:0] den);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] q;
    mag_n = num[31] ? (32'd0 - num) : num;
    mag_d = den[31] ? (32'd0 - den) : den;
    if (mag_d == 32'd0) return 32'd0;
    q = mag_n / mag_d;
    return (num[31] ^ den[31]) ? (32'd0 - q) : q;
  endfunction

  // Apply one transferred token to the shadow stack
  function void note_token(logic [rsa_pkg::OP_W-1:0] op, logic [31:0] val);
    logic [31:0] top;
    logic [31:0] nxt;
    logic [31:0] res;
    case (op)
      rsa_pkg::OP_PUSH: begin
        if (depth < rsa_pkg::STACK_DEPTH) begin
          slots[depth] = val;
          depth++;
        end
      end
      rsa_pkg::OP_PRINT: begin
        if (depth != 0) expected_prints.push_back(slots[depth-1]);
      end
      rsa_pkg::OP_SWAP: begin
        if (depth >= 2) begin
          top = slots[depth-1];
          slots[depth-1] = slots[depth-2];
          slots[depth-2] = top;
        end
      end
      rsa_pkg::OP_DUP: begin
        if (depth != 0 && depth < rsa_pkg::STACK_DEPTH) begin
          slots[depth] = slots[depth-1];
          depth++;
        end
      end
      rsa_pkg::OP_ADD, rsa_pkg::OP_SUB, rsa_pkg::OP_MUL, rsa_pkg::OP_DIV: begin
        if (depth >= 2) begin
          top = slots[depth-1];
          nxt = slots[depth-2];
          case (op)
            rsa_pkg::OP_ADD: res = nxt + top;
            rsa_pkg::OP_SUB: res = nxt - top;
            rsa_pkg::OP_MUL: res = nxt * top;
            default:         res = quotient_trunc(nxt, top);
          endcase
          depth--;
          slots[depth-1] = res;
        end
      end
      default: ;
    endcase
  endfunction

  // Compare one printed value with the oldest pending print
  function void check_print(logic [31:0] actual);
    logic [31:0] want;
    if (expected_prints.size() == 0) begin
      errors++;
      $display("%0t: unexpected printed_value %0d (0x%08h), no print pending",
               $time, $signed(actual), actual);
      return;
    end
    want = expected_prints.pop_front();
    if (actual !== want) begin
      errors++;
      $display("%0t: printed_value mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
               $time, $signed(want), want, $signed(actual), actual);
    end
  endfunction

  function int pending();
    return expected_prints.size();
  endfunction
endclass

module tb_top;
  import rsa_pkg::*;

  // Codes 8 and up carry no operation
  localparam logic [OP_W-1:0] OP_IGNORE = 4'd8;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [31:0] VAL_NEG1 = 32'hffff_ffff;
  localparam int TOKENS_PER_PHASE = 550;

  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } burst_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] operation = OP_PUSH;
  logic signed [DATA_W-1:0] operand_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] printed_value;

  int send_idle_pct = 34;
  int recv_stall_pct = 58;
  calc_scoreboard sb;

  rpn_stack_alu uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .operand_value (operand_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .printed_value (printed_value)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_print(printed_value);
  end

  // Drive one token, starting and ending at a falling edge
  task automatic send_token(logic [OP_W-1:0] op, logic [31:0] val);
    // Idle cycle by cycle before presenting the token
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    operation     = op;
    operand_value = val;
    do @(posedge clk); while (!in_ready);
    sb.note_token(op, val);
    @(negedge clk);
  endtask

  // Hold off the sender until every pending print has come back
  task automatic wait_for_prints();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return VAL_NEG1;
      3:       return VAL_MIN;
      4:       return VAL_MAX;
      5, 6:    return 32'($signed($urandom_range(40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_arith();
    case ($urandom_range(3))
      0:       return OP_ADD;
      1:       return OP_SUB;
      2:       return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  // Weight the token mix by burst mode
  task automatic send_random_token(burst_mode_t mode);
    int r;
    int push_lim;
    int dup_lim;
    int print_lim;
    int swap_lim;
    int arith_lim;
    logic [OP_W-1:0] op;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        push_lim = 55; dup_lim = 70; print_lim = 85; swap_lim = 90; arith_lim = 95;
      end
      MODE_DRAIN: begin
        push_lim = 10; dup_lim = 15; print_lim = 35; swap_lim = 45; arith_lim = 93;
      end
      default: begin
        push_lim = 35; dup_lim = 42; print_lim = 62; swap_lim = 72; arith_lim = 95;
      end
    endcase
    if (r < push_lim)       op = OP_PUSH;
    else if (r < dup_lim)   op = OP_DUP;
    else if (r < print_lim) op = OP_PRINT;
    else if (r < swap_lim)  op = OP_SWAP;
    else if (r < arith_lim) op = pick_arith();
    else                    op = OP_IGNORE + 4'($urandom_range(7));
    send_token(op, (op == OP_PUSH) ? pick_operand() : $urandom);
  endtask

  task automatic run_bursts(int tokens);
    int sent;
    int burst_len;
    burst_mode_t mode;
    sent = 0;
    while (sent < tokens) begin
      mode = burst_mode_t'($urandom_range(2));
      burst_len = $urandom_range(10, 40);
      repeat (burst_len) send_random_token(mode);
      sent += burst_len;
    end
  endtask

  // Corner cases: empty and single-entry stack, wrap, division limits, codes
  task automatic run_directed();
    send_token(OP_PRINT, 32'd0);
    send_token(OP_SWAP, 32'd0);
    send_token(OP_DUP, 32'd0);
    send_token(OP_ADD, 32'd0);
    send_token(OP_PUSH, VAL_MIN);
    send_token(OP_SWAP, 32'd0);
    send_token(OP_DIV, 32'd0);
    send_token(OP_PUSH, VAL_NEG1);
    send_token(OP_DIV, 32'd0);
    send_token(OP_PRINT, 32'd0);
    send_token(OP_PUSH, 32'd0);
    send_token(OP_DIV, 32'd0);
    send_token(OP_PRINT, 32'd0);
    send_token(OP_PUSH, VAL_MAX);
    send_token(OP_DUP, 32'd0);
    send_token(OP_ADD, 32'd0);
    send_token(OP_PUSH, 32'hffff_fff9);
    send_token(OP_PUSH, 32'd2);
    send_token(OP_DIV, 32'd0);
    send_token(OP_SWAP, 32'd0);
    send_token(OP_SUB, 32'd0);
    send_token(OP_MUL, 32'd0);
    send_token(OP_IGNORE, VAL_NEG1);
    send_token(OP_IGNORE + 4'd7, VAL_NEG1);
    send_token(OP_PRINT, 32'd0);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    // Sender mostly busy, receiver stalls often
    run_bursts(TOKENS_PER_PHASE);
    wait_for_prints();

    // Sender idles often, receiver mostly ready
    send_idle_pct  = 58;
    recv_stall_pct = 34;
    run_bursts(TOKENS_PER_PHASE);
    wait_for_prints();

    // Back-to-back on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_bursts(TOKENS_PER_PHASE);

    // Drain and let a last division settle
    wait_for_prints();
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d prints still pending", $time, sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
